FILE: rtl/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg
// shared widths, operation codes and register indexes of the index allocator
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 16;
  localparam int CNT_W     = 11;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_INDEX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 1'd1;

  // register reset values
  localparam logic [IDX_W-1:0] BASE_INDEX_RST = 16'd0;
  localparam logic [CNT_W-1:0] POOL_SIZE_RST  = 11'd1024;

  typedef logic [IDX_W-1:0] index_t;
  typedef logic [CNT_W-1:0] count_t;

endpackage

FILE: rtl/fla_if.sv
// ----------------------------------------------------------------------------
// fla_req_if / fla_rsp_if
// request and response channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface fla_req_if import fla_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  index_t          index;

  modport source (output valid, output operation, output index, input ready);
  modport sink   (input valid, input operation, input index, output ready);
endinterface

interface fla_rsp_if import fla_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   ok;
  index_t index_out;
  count_t free_count;
  count_t used_count;

  modport source (output valid, output ok, output index_out, output free_count,
                  output used_count, input ready);
  modport sink   (input valid, input ok, input index_out, input free_count,
                  input used_count, output ready);
endinterface

FILE: rtl/fla_ram.sv
// ----------------------------------------------------------------------------
// fla_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/free_list_index_allocator.sv
// ----------------------------------------------------------------------------
// free_list_index_allocator
// reserve / free / query of indices in a window, lifo free stack in ram
// ----------------------------------------------------------------------------
// sequence: a request word is read in the accept state and executed in the
//   execute state once the output register is free; the result is registered
// requests: a new word is taken only after the previous one has finished,
//   due to the read-modify-write of the free stack ram and the free flag ram
//   (read in the accept cycle, write-back in the execute cycle)
// reset: registers to base 0 / size 1024, stack and high-water mark empty;
//   no clearing pass, a flag is written as its offset is first handed out
module free_list_index_allocator
  import fla_pkg::*;
#(
  parameter int POOL_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  fla_req_if.sink              req,
  fla_rsp_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // offset width follows the ram depth
  localparam int OFF_W     = POOL_DEPTH > 1 ? $clog2(POOL_DEPTH) : 1;
  // effective capacity never exceeds what an 11-bit pool size can ask for
  localparam int DEPTH_CAP = POOL_DEPTH > 2047 ? 2047 : POOL_DEPTH;

  localparam logic ST_ACCEPT = 1'b0;
  localparam logic ST_EXEC   = 1'b1;

  // configuration registers
  index_t base_index;
  count_t pool_size;

  // allocator state
  count_t stack_count;
  count_t high_water;
  logic   state;

  // request captured in the accept cycle
  logic [OP_W-1:0] op_q;
  index_t          off_q;
  logic            lo_ok_q;   // index at or above base
  logic            hi_ok_q;   // index below base + capacity

  // ram ports
  logic             stk_we;
  logic [OFF_W-1:0] stk_waddr;
  logic [OFF_W-1:0] stk_raddr;
  logic [OFF_W-1:0] stk_rdata;
  logic             flg_we;
  logic [OFF_W-1:0] flg_waddr;
  logic             flg_wdata;
  logic [OFF_W-1:0] flg_raddr;
  logic             flg_rdata;
  logic             rd_en;

  // execute-cycle results
  count_t cap;
  index_t off_in;
  logic   done;
  logic   res_ok;
  index_t res_index;
  count_t stack_count_next;
  count_t high_water_next;
  logic   below_hw;

  // capacity saturates at the ram depth
  assign cap = (pool_size > CNT_W'(DEPTH_CAP)) ? CNT_W'(DEPTH_CAP) : pool_size;

  assign req.ready = (state == ST_ACCEPT);
  assign rd_en     = req.valid && req.ready;
  assign off_in    = req.index - base_index;

  // the word finishes once the output register can take the result
  assign done = (state == ST_EXEC) && (!rsp.valid || rsp.ready);

  // reads go out in the accept cycle, data is back for the execute cycle
  assign stk_raddr = OFF_W'(stack_count - CNT_W'(1));
  assign flg_raddr = off_in[OFF_W-1:0];

  assign below_hw = off_q < IDX_W'(high_water);

  always_comb begin
    res_ok           = 1'b0;
    res_index        = '0;
    stack_count_next = stack_count;
    high_water_next  = high_water;
    stk_we           = 1'b0;
    stk_waddr        = OFF_W'(stack_count);
    flg_we           = 1'b0;
    flg_waddr        = off_q[OFF_W-1:0];
    flg_wdata        = 1'b0;
    unique case (op_q)
      OP_RESERVE: begin
        if (stack_count != '0) begin
          // pop the most recently freed offset
          res_ok           = 1'b1;
          res_index        = base_index + IDX_W'(stk_rdata);
          stack_count_next = stack_count - CNT_W'(1);
          flg_we           = 1'b1;
          flg_waddr        = stk_rdata;
        end else if (high_water < cap) begin
          // fresh offset; its flag is cleared as it enters the used range
          res_ok          = 1'b1;
          res_index       = base_index + IDX_W'(high_water);
          high_water_next = high_water + CNT_W'(1);
          flg_we          = 1'b1;
          flg_waddr       = OFF_W'(high_water);
        end
      end
      OP_FREE: begin
        if (lo_ok_q && hi_ok_q && below_hw && !flg_rdata &&
            (32'(stack_count) < 32'(POOL_DEPTH))) begin
          res_ok           = 1'b1;
          stack_count_next = stack_count + CNT_W'(1);
          stk_we           = 1'b1;
          flg_we           = 1'b1;
          flg_wdata        = 1'b1;
        end
      end
      OP_QUERY: begin
        res_ok = lo_ok_q && below_hw && !flg_rdata;
      end
      default: begin
        // unknown operation: counts only
      end
    endcase
    if (!done) begin
      stk_we = 1'b0;
      flg_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_index  <= BASE_INDEX_RST;
      pool_size   <= POOL_SIZE_RST;
      stack_count <= '0;
      high_water  <= '0;
      state       <= ST_ACCEPT;
      rsp.valid   <= 1'b0;
    end else begin
      // a write to either register clears the allocator
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASE_INDEX: base_index <= cfg_data;
          REG_POOL_SIZE:  pool_size  <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
        stack_count <= '0;
        high_water  <= '0;
      end else if (done) begin
        stack_count <= stack_count_next;
        high_water  <= high_water_next;
      end

      unique case (state)
        ST_ACCEPT: begin
          if (rd_en) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (done) begin
            state <= ST_ACCEPT;
          end
        end
        default: state <= ST_ACCEPT;
      endcase

      if (done) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // request capture and output word, no reset needed
  always_ff @(posedge clk) begin
    if (rd_en) begin
      op_q    <= req.operation;
      off_q   <= off_in;
      lo_ok_q <= req.index >= base_index;
      hi_ok_q <= {1'b0, req.index} < ({1'b0, base_index} + (IDX_W + 1)'(cap));
    end
    if (done) begin
      rsp.ok         <= res_ok;
      rsp.index_out  <= res_index;
      rsp.free_count <= cap - high_water_next + stack_count_next;
      rsp.used_count <= high_water_next - stack_count_next;
    end
  end

  // lifo of freed offsets
  fla_ram #(
    .WIDTH (OFF_W),
    .DEPTH (POOL_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (off_q[OFF_W-1:0]),
    .re    (rd_en),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // one bit per offset, set while the offset sits on the stack
  fla_ram #(
    .WIDTH (1),
    .DEPTH (POOL_DEPTH)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flg_we),
    .waddr (flg_waddr),
    .wdata (flg_wdata),
    .re    (rd_en),
    .raddr (flg_raddr),
    .rdata (flg_rdata)
  );

endmodule
